### rtl/mrrc_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the response checker.
package mrrc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
  localparam logic [8:0] POS_MAX = 9'd511;
  localparam logic [8:0] POS_FUNC = 9'd1;
  localparam logic [8:0] POS_COUNT = 9'd2;
  localparam logic [8:0] POS_FIRST_DATA = 9'd3;
  localparam logic [8:0] POS_MIN_LAST = 9'd4;
  localparam logic [9:0] FRAME_OVERHEAD_LAST = 10'd4;
  localparam logic [8:0] HEADER_LAST = 9'd2;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] count;
    logic       ok;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/mrrc_frame_core.sv
// Frame state, CRC accumulation and per-byte result decision for the response checker.
module mrrc_frame_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         byte_in,
  input  logic               last_in,
  input  logic [7:0]         max_payload,
  output logic               has_result,
  output mrrc_pkg::result_t  result
);

  logic [15:0] crc_acc;
  logic [8:0]  byte_position;
  logic [7:0]  function_seen;
  logic [7:0]  declared_count;
  logic [7:0]  older_byte;
  logic [7:0]  newer_byte;

  logic [15:0] crc_acc_next;
  logic [8:0]  byte_position_next;
  logic [7:0]  function_seen_next;
  logic [7:0]  declared_count_next;
  logic        frame_pass;
  logic        in_payload;

  always_comb begin
    crc_acc_next = crc_acc;
    if (byte_position >= mrrc_pkg::POS_COUNT) begin
      crc_acc_next = mrrc_pkg::crc_feed(crc_acc, older_byte);
    end
    function_seen_next = (byte_position == mrrc_pkg::POS_FUNC) ? byte_in : function_seen;
    declared_count_next = (byte_position == mrrc_pkg::POS_COUNT) ? byte_in : declared_count;
    byte_position_next = (byte_position < mrrc_pkg::POS_MAX) ? byte_position + 9'd1
                                                             : byte_position;
    frame_pass = (byte_position >= mrrc_pkg::POS_MIN_LAST)
              && (crc_acc_next == {byte_in, newer_byte})
              && (function_seen_next == mrrc_pkg::FUNC_READ_HOLDING)
              && ({1'b0, byte_position} ==
                  ({2'b00, declared_count_next} + mrrc_pkg::FRAME_OVERHEAD_LAST))
              && (declared_count_next <= max_payload);
    in_payload = (byte_position >= mrrc_pkg::POS_FIRST_DATA)
              && ({1'b0, byte_position} <=
                  ({2'b00, declared_count_next} + {1'b0, mrrc_pkg::HEADER_LAST}));
    has_result = last_in || in_payload;
    if (last_in) begin
      result.kind  = mrrc_pkg::KIND_VERDICT;
      result.data  = 8'h00;
      result.count = frame_pass ? declared_count_next : 8'h00;
      result.ok    = frame_pass;
    end else begin
      result.kind  = mrrc_pkg::KIND_DATA;
      result.data  = byte_in;
      result.count = 8'h00;
      result.ok    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_in)) begin
      crc_acc        <= mrrc_pkg::CRC_INIT;
      byte_position  <= '0;
      function_seen  <= '0;
      declared_count <= '0;
      older_byte     <= '0;
      newer_byte     <= '0;
    end else if (step) begin
      crc_acc        <= crc_acc_next;
      byte_position  <= byte_position_next;
      function_seen  <= function_seen_next;
      declared_count <= declared_count_next;
      older_byte     <= newer_byte;
      newer_byte     <= byte_in;
    end
  end

endmodule

### rtl/modbus_read_response_checker.sv
// Top level of the Modbus RTU read-holding-registers response checker.
//
//   channel   signals                                      direction
//   in        in_valid/in_ready, rx_byte, frame_end         input words
//   out       out_valid/out_ready, result_kind, data_byte,  result words
//             payload_count, frame_ok
//   cfg       cfg_valid/cfg_ready, max_payload              register write
//
// One word is accepted per cycle while in_ready is high; a word passes an input register and
// then the result register, and out_valid rises once a word with a result is written there.
// The CRC update for one byte is done combinationally between the two registers.
// Reset clears the frame state, sets max_payload to 255 and empties both registers.
// A stalled result register holds the input register, which then holds in_ready low.
module modbus_read_response_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       frame_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       result_kind,
  output logic [7:0] data_byte,
  output logic [7:0] payload_count,
  output logic       frame_ok,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] max_payload
);

  logic              cfg_max;
  logic [7:0]        max_reg;
  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_last;
  logic              s1_step;
  logic              has_result;
  mrrc_pkg::result_t result;
  mrrc_pkg::result_t out_reg;

  assign cfg_max   = cfg_valid;
  assign cfg_ready = 1'b1;
  assign s1_step   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_reg <= 8'hFF;
    end else if (cfg_max) begin
      max_reg <= max_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= rx_byte;
      s1_last <= frame_end;
    end
  end

  mrrc_frame_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (s1_step),
    .byte_in    (s1_byte),
    .last_in    (s1_last),
    .max_payload(max_reg),
    .has_result (has_result),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_step) begin
      out_valid <= has_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step && has_result) begin
      out_reg <= result;
    end
  end

  assign result_kind   = out_reg.kind;
  assign data_byte     = out_reg.data;
  assign payload_count = out_reg.count;
  assign frame_ok      = out_reg.ok;

endmodule

### rtl/mrrc_checker.sv
// Port-level assertions for the response checker and the bind that attaches them.
module mrrc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       result_kind,
  input logic [7:0] data_byte,
  input logic [7:0] payload_count,
  input logic       frame_ok
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(data_byte))
    else $error("Result word changed while stalled.");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == mrrc_pkg::KIND_DATA |-> !frame_ok && payload_count == 8'h00)
    else $error("Data word carries verdict fields.");

  a_verdict_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == mrrc_pkg::KIND_VERDICT |-> data_byte == 8'h00)
    else $error("Verdict word carries a data byte.");

  a_fail_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_ok |-> payload_count == 8'h00)
    else $error("Rejected frame reports a payload count.");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("Result word valid right after reset.");

endmodule

bind modbus_read_response_checker mrrc_checker u_mrrc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_kind  (result_kind),
  .data_byte    (data_byte),
  .payload_count(payload_count),
  .frame_ok     (frame_ok)
);
